// ----- sv/ptad_pkg.sv -----
// package with shared types and constants for the partition table add/delete core
`timescale 1ns / 1ps
`default_nettype none

package ptad_pkg;

    // stream payload widths
    localparam int S_TDATA_W  = 152;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 32;

    // configuration channel widths
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // field widths fixed by the interface
    localparam int MINOR_W    = 8;
    localparam int PNO_W      = 8;
    localparam int BYTES_W    = 64;
    localparam int SHIFT_W    = 3;
    localparam int DCOUNT_W   = 3;
    localparam int SIZE_W     = 30;
    localparam int SPAN_W     = 8;

    // bytes to sectors
    localparam int SECTOR_SHIFT = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PART_SHIFT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_COUNT = 8'd1;

    // reset values of the configuration registers
    localparam logic [SHIFT_W-1:0]  PART_SHIFT_RST  = 3'd6;
    localparam logic [DCOUNT_W-1:0] DRIVE_COUNT_RST = 3'd4;

    // request kinds
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_DEL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_NXIO  = 2'd2,
        ST_BUSY  = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ----- sv/partition_table_add_delete_core.sv -----
// top level of the partition table add/delete core
`timescale 1ns / 1ps
`default_nettype none

// Partition table add/delete engine. Holds (start sector, sector count) for every
// minor in one table ram, 2^shift minors per drive (shift is configuration register
// 0), the first minor of each drive being the whole disk. An add item converts byte
// start/length to 512-byte sectors, validates drive, minor and partition number,
// rejects an entry in use and any overlap with the drive's partition entries past
// the whole-disk one, then writes the entry; a delete item clears an existing
// entry unless target_busy is set. Every item returns exactly one result: status
// and size in 1 KiB blocks. Items are handled one at a time through the single
// table read port; the overlap scan of an add makes one table read per minor of
// the drive past the whole-disk one. After reset the table is swept to zero, one
// entry a cycle over all 2^MINOR_BITS entries; s_tready stays low meanwhile,
// configuration writes are taken at any time. A finished result waits in an output
// register, so the next item can be accepted before m_tready comes back.
module partition_table_add_delete_core #(
    parameter int MINOR_BITS  = 8,
    parameter int SECTOR_BITS = 31,
    parameter int MAX_DRIVES  = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input item stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // device_minor[7:0], part_number[15:8], start_bytes[79:16],
    // length_bytes[143:80], target_busy[144], zero fill [151:145]
    input  wire logic [ptad_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd[0]
    input  wire logic [ptad_pkg::S_TUSER_W-1:0]    s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], size_blocks[31:2]
    output logic      [ptad_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ptad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ptad_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import ptad_pkg::*;

    localparam int DEPTH  = 1 << MINOR_BITS;
    localparam int ENT_W  = 2 * SECTOR_BITS;
    localparam int HI_SH  = SECTOR_SHIFT + SECTOR_BITS;
    localparam int EXT_W  = (MINOR_BITS > MINOR_W + 1) ? MINOR_BITS : MINOR_W + 1;
    localparam logic [MINOR_W-1:0] MAXD = MINOR_W'(MAX_DRIVES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_LOOKUP,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [MINOR_BITS-1:0]   clr_reg, clr_next;

    // configuration
    logic [SHIFT_W-1:0]      shift_reg, shift_next;
    logic [DCOUNT_W-1:0]     dcount_reg, dcount_next;

    // captured item
    logic                    cmd_reg, cmd_next;
    logic [MINOR_W-1:0]      minor_reg, minor_next;
    logic [PNO_W-1:0]        pno_reg, pno_next;
    logic [SECTOR_BITS-1:0]  ps_reg, ps_next;
    logic [SECTOR_BITS-1:0]  pl_reg, pl_next;
    logic [SECTOR_BITS:0]    pend_reg, pend_next;
    logic                    bytes_ok_reg, bytes_ok_next;
    logic                    busy_reg, busy_next;

    // overlap scan
    logic [SPAN_W-1:0]       i_reg, i_next;
    logic                    cmp_vld_reg, cmp_vld_next;

    // pending and output result
    status_t                 res_status_reg, res_status_next;
    logic [SIZE_W-1:0]       res_size_reg, res_size_next;
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [SIZE_W-1:0]       m_size_reg, m_size_next;

    // table ram
    logic                    ram_we;
    logic [MINOR_BITS-1:0]   ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic [MINOR_BITS-1:0]   ram_raddr;
    logic [ENT_W-1:0]        ram_rdata;

    // decode of the captured item
    logic [BYTES_W-1:0]      in_start;
    logic [BYTES_W-1:0]      in_len;
    logic [MINOR_W-1:0]      drive;
    logic [MINOR_W-1:0]      first;
    logic [MINOR_W-1:0]      present;
    logic                    drive_ok;
    logic                    minor_ok;
    logic                    part_ok;
    logic [SPAN_W-1:0]       span;
    logic [EXT_W-1:0]        idx_sum;
    logic [EXT_W-1:0]        scan_sum;
    logic [MINOR_BITS-1:0]   idx;
    logic [MINOR_BITS-1:0]   scan_addr;
    logic [SECTOR_BITS-1:0]  rd_start;
    logic [SECTOR_BITS-1:0]  rd_sec;
    logic [SECTOR_BITS:0]    rd_end;
    logic                    overlap;
    logic                    issue;
    logic                    out_free;
    logic                    in_fire;

    assign in_start = s_tdata[79:16];
    assign in_len   = s_tdata[143:80];

    // drive and partition decode, all from registered fields
    assign drive    = minor_reg >> shift_reg;
    assign first    = MINOR_W'(drive << shift_reg);
    assign present  = ({5'd0, dcount_reg} > MAXD) ? MAXD : {5'd0, dcount_reg};
    assign drive_ok = drive < present;
    assign minor_ok = (first == minor_reg);
    assign part_ok  = !pno_reg[PNO_W-1] && (pno_reg[PNO_W-2:0] != '0)
                    && ((pno_reg >> shift_reg) == '0);
    assign span     = SPAN_W'(1) << shift_reg;

    // table index wraps at the table size
    assign idx_sum   = EXT_W'(first) + EXT_W'(pno_reg[PNO_W-2:0]);
    assign scan_sum  = EXT_W'(first) + EXT_W'(i_reg);
    assign idx       = idx_sum[MINOR_BITS-1:0];
    assign scan_addr = scan_sum[MINOR_BITS-1:0];

    // entry read back from the table
    assign rd_start = ram_rdata[ENT_W-1:SECTOR_BITS];
    assign rd_sec   = ram_rdata[SECTOR_BITS-1:0];
    assign rd_end   = {1'b0, rd_start} + {1'b0, rd_sec};
    assign overlap  = !((pend_reg <= {1'b0, rd_start}) || ({1'b0, ps_reg} >= rd_end));

    assign issue    = (i_reg < span);
    assign out_free = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {m_size_reg, m_status_reg};

    ptad_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        shift_next      = shift_reg;
        dcount_next     = dcount_reg;
        cmd_next        = cmd_reg;
        minor_next      = minor_reg;
        pno_next        = pno_reg;
        ps_next         = ps_reg;
        pl_next         = pl_reg;
        pend_next       = pend_reg;
        bytes_ok_next   = bytes_ok_reg;
        busy_next       = busy_reg;
        i_next          = i_reg;
        cmp_vld_next    = 1'b0;
        res_status_next = res_status_reg;
        res_size_next   = res_size_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_size_next     = m_size_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx;
        ram_wdata       = '0;
        ram_raddr       = (state_reg == S_CHECK) ? idx : scan_addr;

        // register writes, low three bits kept
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_PART_SHIFT) begin
                shift_next = cfg_data[SHIFT_W-1:0];
            end else if (cfg_index == REG_DRIVE_COUNT) begin
                dcount_next = cfg_data[DCOUNT_W-1:0];
            end
        end

        case (state_reg)
            S_CLEAR: begin
                // zero the table after reset
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + MINOR_BITS'(1);
                if (clr_reg == {MINOR_BITS{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    cmd_next      = s_tuser[0];
                    minor_next    = s_tdata[7:0];
                    pno_next      = s_tdata[15:8];
                    busy_next     = s_tdata[144];
                    ps_next       = SECTOR_BITS'(in_start >> SECTOR_SHIFT);
                    pl_next       = SECTOR_BITS'(in_len >> SECTOR_SHIFT);
                    pend_next     = (SECTOR_BITS+1)'(in_start >> SECTOR_SHIFT)
                                  + (SECTOR_BITS+1)'(in_len >> SECTOR_SHIFT);
                    // negative or wider than a sector number
                    bytes_ok_next = !in_start[BYTES_W-1] && ((in_start >> HI_SH) == '0)
                                  && !in_len[BYTES_W-1] && ((in_len >> HI_SH) == '0);
                    state_next    = S_CHECK;
                end
            end
            S_CHECK: begin
                // table read of the target entry goes out this cycle
                res_size_next = '0;
                state_next    = S_DONE;
                if (cmd_reg == CMD_ADD) begin
                    if (!bytes_ok_reg) begin
                        res_status_next = ST_INVAL;
                    end else if (!drive_ok) begin
                        res_status_next = ST_NXIO;
                    end else if (!minor_ok || !part_ok) begin
                        res_status_next = ST_INVAL;
                    end else begin
                        state_next = S_LOOKUP;
                    end
                end else begin
                    if (!minor_ok || !part_ok) begin
                        res_status_next = ST_INVAL;
                    end else begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                state_next = S_DONE;
                if (cmd_reg == CMD_ADD) begin
                    if (rd_sec != '0) begin
                        res_status_next = ST_BUSY;
                    end else begin
                        i_next     = SPAN_W'(1);
                        state_next = S_SCAN;
                    end
                end else begin
                    if (!drive_ok || (rd_sec == '0)) begin
                        res_status_next = ST_NXIO;
                    end else if (busy_reg) begin
                        res_status_next = ST_BUSY;
                    end else begin
                        ram_we          = 1'b1;
                        res_status_next = ST_OK;
                    end
                end
            end
            S_SCAN: begin
                // one read issued and one compare done per cycle
                cmp_vld_next = issue;
                if (issue) begin
                    i_next = i_reg + SPAN_W'(1);
                end
                if (cmp_vld_reg && overlap) begin
                    cmp_vld_next    = 1'b0;
                    res_status_next = ST_BUSY;
                    state_next      = S_DONE;
                end else if (!issue) begin
                    ram_we          = 1'b1;
                    ram_wdata       = {ps_reg, pl_reg};
                    res_status_next = ST_OK;
                    res_size_next   = SIZE_W'(64'(pl_reg) >> 1);
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_size_next   = res_size_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            shift_reg    <= PART_SHIFT_RST;
            dcount_reg   <= DRIVE_COUNT_RST;
            cmp_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            shift_reg    <= shift_next;
            dcount_reg   <= dcount_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        minor_reg      <= minor_next;
        pno_reg        <= pno_next;
        ps_reg         <= ps_next;
        pl_reg         <= pl_next;
        pend_reg       <= pend_next;
        bytes_ok_reg   <= bytes_ok_next;
        busy_reg       <= busy_next;
        i_reg          <= i_next;
        res_status_reg <= res_status_next;
        res_size_reg   <= res_size_next;
        m_status_reg   <= m_status_next;
        m_size_reg     <= m_size_next;
    end

`ifndef SYNTH
    // one item in flight: an accepted item is never followed by another at once
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("item accepted while previous one still in work");

    // a new result only comes out of the done state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    // compare slot only valid while scanning
    a_cmp_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (state_reg == S_SCAN))
        else $error("scan compare outside scan");

    // only a successful add reports a size
    a_size_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_status_reg != ST_OK)) |-> (m_size_reg == '0))
        else $error("nonzero size on failed request");

    // no table write while idle or waiting to hand over a result
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == S_CLEAR) || (state_reg == S_LOOKUP)
                    || (state_reg == S_SCAN)))
        else $error("table write in wrong state");
`endif

endmodule

`default_nettype wire

// ----- sv/ptad_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ptad_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for the partition table add/delete core
`timescale 1ns / 1ps

module testbench;
    import ptad_pkg::*;

    localparam int MINOR_BITS  = 8;
    localparam int SECTOR_BITS = 31;
    localparam int MAX_DRIVES  = 4;
    localparam int TABLE_DEPTH = 1 << MINOR_BITS;
    // widest drive (shift 7) scans 127 entries, plus overhead
    localparam int DRAIN_CYCLES = (1 << 7) + 16;
    // an index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  minor;
        logic [7:0]  pno;       // signed partition number
        logic [63:0] start_b;
        logic [63:0] len_b;
        logic        busy;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [29:0] size_blocks;
    } outcome_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // device_minor, part_number, start_bytes, length_bytes, target_busy, zero fill
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // cmd
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // status, size_blocks
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted table contents and settings
    logic [SECTOR_BITS-1:0] part_start [TABLE_DEPTH];
    logic [SECTOR_BITS-1:0] part_len   [TABLE_DEPTH];
    logic [SHIFT_W-1:0]     cur_shift  = PART_SHIFT_RST;
    logic [DCOUNT_W-1:0]    cur_drives = DRIVE_COUNT_RST;

    // results owed by the block, oldest first
    outcome_t outcome_fifo [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int results_seen  = 0;

    partition_table_add_delete_core #(
        .MINOR_BITS (MINOR_BITS),
        .SECTOR_BITS(SECTOR_BITS),
        .MAX_DRIVES (MAX_DRIVES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 aclk = ~aclk;

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] result %0d mismatch: %s", $time, results_seen, what);
    endtask

    function automatic int drives_present();
        return (cur_drives > MAX_DRIVES) ? MAX_DRIVES : int'(cur_drives);
    endfunction

    // applies one request to the predicted table and returns the result it owes
    function automatic outcome_t apply_to_table(input request_t r);
        outcome_t    o;
        logic [63:0] ps, pl, s, e;
        logic [7:0]  drive, first, idx, k;
        int          span, present, i;
        logic        bytes_ok, pno_ok;
        o.status      = ST_OK;
        o.size_blocks = '0;
        span    = 1 << cur_shift;
        present = drives_present();
        drive   = r.minor >> cur_shift;
        first   = drive << cur_shift;
        idx     = first + r.pno;
        pno_ok  = ($signed(r.pno) > 0) && ($signed(r.pno) < span);
        ps = r.start_b >> SECTOR_SHIFT;
        pl = r.len_b >> SECTOR_SHIFT;
        bytes_ok = !r.start_b[63] && !r.len_b[63]
                   && (ps >> SECTOR_BITS) == 0 && (pl >> SECTOR_BITS) == 0;
        if (r.cmd == CMD_ADD) begin
            if (!bytes_ok) begin
                o.status = ST_INVAL;
            end else if (drive >= present) begin
                o.status = ST_NXIO;
            end else if (first != r.minor || !pno_ok) begin
                o.status = ST_INVAL;
            end else begin
                if (part_len[idx] != 0)
                    o.status = ST_BUSY;
                // skips the whole-disk minor, includes the target slot itself;
                // an empty slot still has a start that can straddle
                for (i = 1; i < span && o.status == ST_OK; i++) begin
                    k = first + 8'(i);
                    s = 64'(part_start[k]);
                    e = s + 64'(part_len[k]);
                    if (!(ps + pl <= s || ps >= e))
                        o.status = ST_BUSY;
                end
                if (o.status == ST_OK) begin
                    part_start[idx] = ps[SECTOR_BITS-1:0];
                    part_len[idx]   = pl[SECTOR_BITS-1:0];
                    o.size_blocks   = pl[30:1];
                end
            end
        end else begin
            if (first != r.minor || !pno_ok) begin
                o.status = ST_INVAL;
            end else if (drive >= present || part_len[idx] == 0) begin
                o.status = ST_NXIO;
            end else if (r.busy) begin
                o.status = ST_BUSY;
            end else begin
                part_start[idx] = '0;
                part_len[idx]   = '0;
            end
        end
        return o;
    endfunction

    function automatic request_t add_req(input logic [7:0] minor, input logic [7:0] pno,
                                         input logic [63:0] start_b, input logic [63:0] len_b);
        request_t r;
        r.cmd     = CMD_ADD;
        r.minor   = minor;
        r.pno     = pno;
        r.start_b = start_b;
        r.len_b   = len_b;
        r.busy    = 1'b0;
        return r;
    endfunction

    function automatic request_t del_req(input logic [7:0] minor, input logic [7:0] pno,
                                         input logic busy);
        request_t r;
        r.cmd     = CMD_DEL;
        r.minor   = minor;
        r.pno     = pno;
        r.start_b = {$urandom, $urandom};
        r.len_b   = {$urandom, $urandom};
        r.busy    = busy;
        return r;
    endfunction

    // mostly whole-disk requests on present drives with small sector ranges, so
    // adds collide and deletes find entries; the rest is noise
    function automatic request_t random_request();
        request_t    r;
        int          span, roll;
        logic [31:0] sec, cnt;
        span  = 1 << cur_shift;
        roll  = $urandom_range(99);
        r.cmd = ($urandom_range(99) < 55) ? CMD_ADD : CMD_DEL;
        // now and then one drive past the last present one
        r.minor = 8'($urandom_range(0, drives_present()) << cur_shift);
        r.pno   = (span > 1) ? 8'($urandom_range(1, span - 1)) : 8'($urandom_range(0, 2));
        sec = ($urandom_range(9) == 0) ? $urandom_range(32'h7FFF_FF00, 32'h7FFF_FFFF)
                                       : $urandom_range(0, 4095);
        cnt = ($urandom_range(19) == 0) ? 32'd0 : $urandom_range(1, 255);
        r.start_b = {24'd0, sec[30:0], 9'($urandom)};
        r.len_b   = {24'd0, cnt[30:0], 9'($urandom)};
        r.busy    = ($urandom_range(99) < 25);
        if (roll < 8) begin
            r.cmd     = 1'($urandom);
            r.minor   = 8'($urandom);
            r.pno     = 8'($urandom);
            r.start_b = {$urandom, $urandom};
            r.len_b   = {$urandom, $urandom};
            r.busy    = 1'($urandom);
        end else if (roll < 16) begin
            r.minor = 8'($urandom);
            r.pno   = 8'($urandom);
        end else if (roll < 20) begin
            r.pno = (roll < 18) ? 8'd0 : 8'(span);
        end
        return r;
    endfunction

    // random gap, then hold the item until taken; valid stays up for back-to-back items
    task automatic send_item(input request_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {7'd0, r.busy, r.len_b, r.start_b, r.pno, r.minor};
        do @(posedge aclk); while (!s_tready);
        outcome_fifo.push_back(apply_to_table(r));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (outcome_fifo.size() != 0)
            @(posedge aclk);
    endtask

    // both registers and an unused index in one burst while idle; upper data bits must be ignored
    task automatic configure(input logic [SHIFT_W-1:0] shift,
                             input logic [DCOUNT_W-1:0] drives);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_index <= REG_PART_SHIFT;
        cfg_data  <= {5'($urandom), shift};
        do @(posedge aclk); while (!cfg_ready);
        cur_shift = shift;
        cfg_index <= REG_DRIVE_COUNT;
        cfg_data  <= {5'($urandom), drives};
        do @(posedge aclk); while (!cfg_ready);
        cur_drives = drives;
        cfg_index <= REG_UNUSED;
        cfg_data  <= 8'($urandom);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_segment(input int count, input logic [SHIFT_W-1:0] shift,
                                  input logic [DCOUNT_W-1:0] drives,
                                  input int send_pct, input int recv_pct);
        configure(shift, drives);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_item(random_request());
    endtask

    task automatic test_add_checks();
        configure(3'd6, 3'd4);
        // drive 0: first entry of 2048 sectors, then a duplicate and an overlap
        send_item(add_req(8'd0, 8'd1, 64'd0, 64'd1048576));
        send_item(add_req(8'd0, 8'd1, 64'd4194304, 64'd512));
        send_item(add_req(8'd0, 8'd2, 64'd51200, 64'd512));
        // last representable sector, top partition number
        send_item(add_req(8'd0, 8'd63, 64'h0000_00FF_FFFF_FFFF, 64'd1023));
        // negative and too-wide byte values
        send_item(add_req(8'd64, 8'd1, 64'h8000_0000_0000_0000, 64'd0));
        send_item(add_req(8'd64, 8'd1, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF));
        send_item(add_req(8'd64, 8'd1, 64'd0, 64'h0000_0100_0000_0000));
        // not a whole-disk minor, then bad partition numbers
        send_item(add_req(8'd255, 8'd1, 64'd0, 64'd512));
        send_item(add_req(8'd64, 8'h80, 64'd0, 64'd512));
        send_item(add_req(8'd64, 8'h7F, 64'd0, 64'd512));
        send_item(add_req(8'd64, 8'd64, 64'd0, 64'd512));
        send_item(add_req(8'd64, 8'd0, 64'd0, 64'd512));
        // zero-length add stays empty, yet its start blocks a straddling add
        send_item(add_req(8'd64, 8'd5, 64'd512000, 64'd0));
        send_item(add_req(8'd64, 8'd6, 64'd506880, 64'd10240));
        send_item(add_req(8'd64, 8'd5, 64'd1024000, 64'd1024));
    endtask

    task automatic test_delete_checks();
        send_item(del_req(8'd0, 8'd1, 1'b1));
        send_item(del_req(8'd0, 8'd1, 1'b0));
        send_item(del_req(8'd0, 8'd1, 1'b0));
        send_item(del_req(8'd1, 8'd1, 1'b0));
        send_item(del_req(8'd0, 8'd0, 1'b1));
    endtask

    task automatic test_drive_count();
        configure(3'd6, 3'd0);
        send_item(add_req(8'd0, 8'd3, 64'd0, 64'd512));
        send_item(del_req(8'd64, 8'd5, 1'b0));
        // counts above the maximum saturate
        configure(3'd6, 3'd7);
        send_item(add_req(8'd192, 8'd63, 64'd0, 64'd512));
    endtask

    task automatic test_shift_extremes();
        configure(3'd0, 3'd4);
        send_item(add_req(8'd2, 8'd1, 64'd0, 64'd512));
        send_item(add_req(8'd5, 8'd1, 64'd0, 64'd512));
        send_item(del_req(8'd0, 8'd1, 1'b0));
        configure(3'd7, 3'd4);
        send_item(add_req(8'd128, 8'd127, 64'd2560000, 64'd512));
        send_item(del_req(8'd128, 8'd127, 1'b0));
    endtask

    task automatic test_random_traffic();
        random_segment(200, 3'd6, 3'd4, 37, 77);
        random_segment(170, 3'd1, 3'd3, 37, 77);
        random_segment(200, 3'd3, 3'd2, 77, 37);
        random_segment(150, 3'd5, 3'd6, 77, 37);
        random_segment(220, 3'd2, 3'd4, 0, 0);
        random_segment(80, 3'd7, 3'd1, 0, 0);
    endtask

    // every accepted result against the oldest owed one
    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (outcome_fifo.size() == 0) begin
                report_mismatch($sformatf("no request pending, tdata %h", m_tdata));
            end else begin
                want = outcome_fifo.pop_front();
                if (m_tdata[1:0] != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tdata[1:0], want.status));
                if (m_tdata[31:2] != want.size_blocks)
                    report_mismatch($sformatf("size_blocks %0d, expected %0d",
                                              m_tdata[31:2], want.size_blocks));
            end
        end
    end

    initial begin : run
        int n;
        for (n = 0; n < TABLE_DEPTH; n++) begin
            part_start[n] = '0;
            part_len[n]   = '0;
        end
        send_idle_pct = 37;
        recv_idle_pct = 77;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_add_checks();
        test_delete_checks();
        test_drive_count();
        test_shift_extremes();
        test_random_traffic();
        wait_results_drained();
        // catch stray results after the last owed one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // slowest legal run: about 1050 items, each up to a full-drive scan plus stalls,
    // and the clearing sweep; the watchdog ends the run if it hangs
    initial begin : watchdog
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/ptad_pkg.sv
sv/ptad_ram.sv
sv/partition_table_add_delete_core.sv
sim/testbench.sv
